>>> design/blft_pkg.sv
// shared types, codes and constants of the boot link frame transceiver
package blft_pkg;

    localparam int BLFT_REPLY_DEPTH = 256;
    localparam int BLFT_FRAME_DEPTH = 256;
    localparam int BLFT_QUEUE_DEPTH = 4;
    localparam int BLFT_QUEUE_AW    = $clog2(BLFT_QUEUE_DEPTH);
    localparam int BLFT_QUEUE_CW    = $clog2(BLFT_QUEUE_DEPTH + 1);

    localparam logic [7:0] BYTE_TIMEOUT_RESET = 8'd20;
    localparam logic [7:0] ACK_CODE_RESET     = 8'h79;
    localparam logic [7:0] NACK_CODE_RESET    = 8'h1F;

    typedef enum logic [2:0] {
        OP_RX_BYTE    = 3'd0,
        OP_TICK       = 3'd1,
        OP_ARM        = 3'd2,
        OP_TX_PUSH    = 3'd3,
        OP_TX_READY   = 3'd4,
        OP_READ_REPLY = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CFG_BYTE_TIMEOUT = 2'd0,
        CFG_ACK_CODE     = 2'd1,
        CFG_NACK_CODE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RX_ACK  = 2'd0,
        RX_LEN  = 2'd1,
        RX_DATA = 2'd2
    } t_rx_mode;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic        last;
        logic        expect_reply;
        logic [15:0] timeout_value;
        logic [7:0]  index;
    } t_in_item;

    typedef struct packed {
        logic        ack_seen;
        logic        nack_seen;
        logic        reply_done;
        logic [15:0] response_left;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_busy;
        logic        rejected;
        logic [7:0]  read_byte;
    } t_out_item;

endpackage

>>> design/blft_in_if.sv
// event channel into the transceiver
interface blft_in_if;
    import blft_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/blft_out_if.sv
// status channel out of the transceiver
interface blft_out_if;
    import blft_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/boot_link_frame_transceiver_core.sv
// top level of the boot link frame transceiver
//
// host side of a bootloader serial link, driven one event at a time
// input channel i_in: one transfer carries one event selected by op
//   rx byte, tick, arm, tx push, tx ready or read reply
// output channel o_out: exactly one status transfer for each event, in order
//   flags, response timer, the byte to send and the reply byte read back
// config port: i_cfg_we with i_cfg_idx and i_cfg_wdata, written while idle
//   index 0 byte timeout, 1 ack code, 2 nack code; other indexes ignored
// status passes a registered front stage (decode and store read), then
//   a write into the result queue, before it is presented on o_out
// throughput: one event per cycle while i_in.ready is high, set by the front stage
//   and one store access per store per cycle
// a four entry result queue decouples the two channels: when o_out stalls
//   events keep flowing until the queue and front stage fill, then
//   i_in.ready drops until the receiver takes a status transfer
// reset (synchronous, active low) clears all link state and loads the
//   default config; the stores keep their contents and need no clearing
module boot_link_frame_transceiver_core #(
    parameter int REPLY_DEPTH = blft_pkg::BLFT_REPLY_DEPTH,
    parameter int FRAME_DEPTH = blft_pkg::BLFT_FRAME_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    blft_in_if.sink     i_in,
    blft_out_if.source  o_out
);
    import blft_pkg::*;

    logic      w_can_take;
    logic      w_take;
    logic      w_front_valid;
    t_out_item w_front_item;

    // accept only with room guaranteed downstream, so the front never stalls
    assign i_in.ready = w_can_take;
    assign w_take     = i_in.valid && w_can_take;

    // decode, link state, stores
    blft_front #(
        .REPLY_DEPTH (REPLY_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_item      (i_in.payload),
        .o_valid     (w_front_valid),
        .o_item      (w_front_item)
    );

    // result queue toward the status receiver
    blft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_front_valid),
        .i_item     (w_front_item),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );
endmodule

>>> design/blft_ram.sv
// generic single write port ram with registered read
module blft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/blft_front.sv
// front end: config registers, event decode, link state, reply and frame stores
module blft_front #(
    parameter int REPLY_DEPTH = blft_pkg::BLFT_REPLY_DEPTH,
    parameter int FRAME_DEPTH = blft_pkg::BLFT_FRAME_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_take,
    input  blft_pkg::t_in_item  i_item,
    output logic                o_valid,
    output blft_pkg::t_out_item o_item
);
    import blft_pkg::*;

    localparam int RA = $clog2(REPLY_DEPTH);
    localparam int FA = $clog2(FRAME_DEPTH);
    localparam int FW = $clog2(FRAME_DEPTH + 1);

    logic [7:0] r_byte_timeout, r_ack_code, r_nack_code;

    logic       r_ack_flag, n_ack_flag;
    logic       r_nack_flag, n_nack_flag;
    logic       r_reply_flag, n_reply_flag;
    t_rx_mode   r_rx_mode, n_rx_mode;
    logic [7:0] r_rx_remaining, n_rx_remaining;
    logic [7:0] r_rx_write_pos, n_rx_write_pos;
    logic [7:0] r_rx_timer, n_rx_timer;
    logic [15:0] r_response_timer, n_response_timer;
    logic [FW-1:0] r_frame_fill, n_frame_fill;
    logic [FW-1:0] r_tx_left, n_tx_left;
    logic [7:0] r_tx_read_pos, n_tx_read_pos;
    logic       r_tx_active, n_tx_active;
    logic [7:0] r_tx_timer, n_tx_timer;

    logic       reply_we, frame_we;
    logic [RA-1:0] reply_waddr, reply_raddr;
    logic [FA-1:0] frame_waddr, frame_raddr;
    logic [7:0] reply_wdata, frame_wdata, reply_rdata, frame_rdata;
    logic       rd_reply, rd_frame, rejected, tx_emit;

    logic       r_s1_valid, r_s1_rd_reply, r_s1_rd_frame;
    t_out_item  r_s1_item;
    t_out_item  s1_item;

    always_comb begin
        n_ack_flag       = r_ack_flag;
        n_nack_flag      = r_nack_flag;
        n_reply_flag     = r_reply_flag;
        n_rx_mode        = r_rx_mode;
        n_rx_remaining   = r_rx_remaining;
        n_rx_write_pos   = r_rx_write_pos;
        n_rx_timer       = r_rx_timer;
        n_response_timer = r_response_timer;
        n_frame_fill     = r_frame_fill;
        n_tx_left        = r_tx_left;
        n_tx_read_pos    = r_tx_read_pos;
        n_tx_active      = r_tx_active;
        n_tx_timer       = r_tx_timer;
        reply_we    = 1'b0;
        reply_waddr = r_rx_write_pos[RA-1:0];
        reply_wdata = i_item.data;
        reply_raddr = i_item.index[RA-1:0];
        frame_we    = 1'b0;
        frame_waddr = r_frame_fill[FA-1:0];
        frame_wdata = i_item.data;
        frame_raddr = r_tx_read_pos[FA-1:0];
        rd_reply    = 1'b0;
        rd_frame    = 1'b0;
        rejected    = 1'b0;
        tx_emit     = 1'b0;

        if (i_take) begin
            unique case (t_op'(i_item.op))
                OP_RX_BYTE: begin
                    n_rx_timer = r_byte_timeout;
                    unique case (r_rx_mode)
                        RX_ACK: begin
                            if (i_item.data == r_ack_code) begin
                                n_ack_flag = 1'b1;
                            end else if (i_item.data == r_nack_code) begin
                                n_nack_flag = 1'b1;
                            end
                            n_rx_timer = '0;
                        end
                        RX_LEN: begin
                            n_rx_remaining = i_item.data;
                            n_rx_mode      = RX_DATA;
                            n_rx_write_pos = '0;
                        end
                        RX_DATA: begin
                            reply_we       = ({1'b0, r_rx_write_pos} < 9'(REPLY_DEPTH));
                            n_rx_write_pos = r_rx_write_pos + 8'd1;
                            if (r_rx_remaining == '0) begin
                                n_rx_timer   = '0;
                                n_rx_mode    = RX_ACK;
                                n_reply_flag = 1'b1;
                            end else begin
                                n_rx_remaining = r_rx_remaining - 8'd1;
                            end
                        end
                        default: begin
                            n_rx_timer = '0;
                            n_rx_mode  = RX_ACK;
                        end
                    endcase
                end
                OP_TICK: begin
                    if (r_response_timer != '0) begin
                        n_response_timer = r_response_timer - 16'd1;
                    end
                    if (r_tx_timer != '0) begin
                        n_tx_timer = r_tx_timer - 8'd1;
                        if (r_tx_timer == 8'd1) begin
                            n_tx_active = 1'b0;
                            n_tx_left   = '0;
                        end
                    end
                    if (r_rx_timer != '0) begin
                        n_rx_timer = r_rx_timer - 8'd1;
                        if (r_rx_timer == 8'd1) begin
                            n_rx_mode = RX_ACK;
                        end
                    end
                end
                OP_ARM: begin
                    n_ack_flag       = 1'b0;
                    n_nack_flag      = 1'b0;
                    n_reply_flag     = 1'b0;
                    n_rx_mode        = i_item.expect_reply ? RX_LEN : RX_ACK;
                    n_response_timer = i_item.timeout_value;
                end
                OP_TX_PUSH: begin
                    if (r_tx_active) begin
                        rejected = 1'b1;
                    end else begin
                        if (r_frame_fill < FW'(FRAME_DEPTH)) begin
                            frame_we     = 1'b1;
                            n_frame_fill = r_frame_fill + FW'(1);
                        end
                        if (i_item.last) begin
                            n_tx_left     = n_frame_fill;
                            n_tx_read_pos = '0;
                            n_tx_active   = 1'b1;
                            n_tx_timer    = r_byte_timeout;
                            n_frame_fill  = '0;
                        end
                    end
                end
                OP_TX_READY: begin
                    if (r_tx_active) begin
                        if (r_tx_left != '0) begin
                            n_tx_left     = r_tx_left - FW'(1);
                            n_tx_timer    = r_byte_timeout;
                            rd_frame      = ({1'b0, r_tx_read_pos} < 9'(FRAME_DEPTH));
                            tx_emit       = 1'b1;
                            n_tx_read_pos = r_tx_read_pos + 8'd1;
                        end else begin
                            n_tx_active = 1'b0;
                            n_tx_timer  = '0;
                        end
                    end
                end
                OP_READ_REPLY: begin
                    rd_reply = ({1'b0, i_item.index} < 9'(REPLY_DEPTH));
                end
                default: begin
                end
            endcase
        end

        s1_item               = '0;
        s1_item.ack_seen      = n_ack_flag;
        s1_item.nack_seen     = n_nack_flag;
        s1_item.reply_done    = n_reply_flag;
        s1_item.response_left = n_response_timer;
        s1_item.tx_valid      = tx_emit;
        s1_item.tx_busy       = n_tx_active;
        s1_item.rejected      = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_timeout   <= BYTE_TIMEOUT_RESET;
            r_ack_code       <= ACK_CODE_RESET;
            r_nack_code      <= NACK_CODE_RESET;
            r_ack_flag       <= 1'b0;
            r_nack_flag      <= 1'b0;
            r_reply_flag     <= 1'b0;
            r_rx_mode        <= RX_ACK;
            r_rx_remaining   <= '0;
            r_rx_write_pos   <= '0;
            r_rx_timer       <= '0;
            r_response_timer <= '0;
            r_frame_fill     <= '0;
            r_tx_left        <= '0;
            r_tx_read_pos    <= '0;
            r_tx_active      <= 1'b0;
            r_tx_timer       <= '0;
            r_s1_valid       <= 1'b0;
            r_s1_rd_reply    <= 1'b0;
            r_s1_rd_frame    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BYTE_TIMEOUT: r_byte_timeout <= i_cfg_wdata;
                    CFG_ACK_CODE:     r_ack_code     <= i_cfg_wdata;
                    CFG_NACK_CODE:    r_nack_code    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_ack_flag       <= n_ack_flag;
            r_nack_flag      <= n_nack_flag;
            r_reply_flag     <= n_reply_flag;
            r_rx_mode        <= n_rx_mode;
            r_rx_remaining   <= n_rx_remaining;
            r_rx_write_pos   <= n_rx_write_pos;
            r_rx_timer       <= n_rx_timer;
            r_response_timer <= n_response_timer;
            r_frame_fill     <= n_frame_fill;
            r_tx_left        <= n_tx_left;
            r_tx_read_pos    <= n_tx_read_pos;
            r_tx_active      <= n_tx_active;
            r_tx_timer       <= n_tx_timer;
            r_s1_valid       <= i_take;
            r_s1_rd_reply    <= rd_reply;
            r_s1_rd_frame    <= rd_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= s1_item;
    end

    blft_ram #(.WIDTH(8), .DEPTH(REPLY_DEPTH)) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (reply_we),
        .i_waddr (reply_waddr),
        .i_wdata (reply_wdata),
        .i_raddr (reply_raddr),
        .o_rdata (reply_rdata)
    );

    blft_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (frame_waddr),
        .i_wdata (frame_wdata),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    // merge store read data into the status of the previous cycle
    always_comb begin
        o_item           = r_s1_item;
        o_item.tx_byte   = r_s1_rd_frame ? frame_rdata : 8'd0;
        o_item.read_byte = r_s1_rd_reply ? reply_rdata : 8'd0;
    end

    assign o_valid = r_s1_valid;
endmodule

>>> design/blft_back.sv
// back end: result queue feeding the status channel
module blft_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  blft_pkg::t_out_item i_item,
    output logic                o_can_take,
    blft_out_if.source          o_out
);
    import blft_pkg::*;

    t_out_item r_q [BLFT_QUEUE_DEPTH];
    logic [BLFT_QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [BLFT_QUEUE_CW-1:0] r_count, n_count;
    logic pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_count = r_count;
        if (i_valid && !pop) begin
            n_count = r_count + BLFT_QUEUE_CW'(1);
        end else if (!i_valid && pop) begin
            n_count = r_count - BLFT_QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_valid) begin
                r_wr_ptr <= r_wr_ptr + BLFT_QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + BLFT_QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

    // room for one more event counting the one still in the front stage
    assign o_can_take = ({1'b0, r_count} + {{BLFT_QUEUE_CW{1'b0}}, i_valid})
                        < (BLFT_QUEUE_CW + 1)'(BLFT_QUEUE_DEPTH);

    assign o_out.valid   = (r_count != '0);
    assign o_out.payload = r_q[r_rd_ptr];
endmodule

>>> design/blft_checker.sv
// port level checks of the transceiver, bound to the top level
module blft_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input blft_pkg::t_out_item i_out_item
);
    import blft_pkg::*;

    // a stalled status transfer stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("status transfer withdrawn while stalled");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("status offered right after reset");

    // an event accepted while no status is offered passes the front stage register and the queue, then is offered
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> ##1 i_out_valid)
        else $error("status missing two cycles after event");

    // rejection and emission only while a frame is in flight
    a_tx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.rejected || i_out_item.tx_valid)
        |-> i_out_item.tx_busy)
        else $error("tx status without a frame in flight");
endmodule

bind boot_link_frame_transceiver_core blft_checker u_blft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

>>> sim/boot_link_frame_transceiver_core_test.sv
// self-checking testbench for the boot link frame transceiver core
`timescale 1ns / 1ps

module boot_link_frame_transceiver_core_test;
    import blft_pkg::*;

    // op codes outside the defined set, the block must only report status
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // status shows up after the front stage and the result queue
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_wdata;

    blft_in_if  in_ch ();
    blft_out_if out_ch ();

    boot_link_frame_transceiver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // shared run state
    t_out_item   expected_status[$];
    int unsigned fail_count;
    int unsigned events_sent;
    int unsigned statuses_checked;
    int unsigned settings_used;
    bit          no_idle;
    int unsigned stall_request;

    // link state as the predictor sees it
    logic [7:0]  lk_byte_timeout;
    logic [7:0]  lk_ack_code;
    logic [7:0]  lk_nack_code;
    logic        lk_ack_flag;
    logic        lk_nack_flag;
    logic        lk_reply_flag;
    t_rx_mode    lk_rx_mode;
    logic [7:0]  lk_rx_left;
    logic [7:0]  lk_rx_pos;
    logic [7:0]  lk_rx_timer;
    logic [15:0] lk_response_timer;
    logic [8:0]  lk_frame_fill;
    logic [8:0]  lk_tx_left;
    logic [7:0]  lk_tx_pos;
    logic        lk_tx_active;
    logic [7:0]  lk_tx_timer;
    logic [7:0]  reply_mem [BLFT_REPLY_DEPTH];
    bit          reply_written [BLFT_REPLY_DEPTH];
    bit          reply_any;
    logic [7:0]  frame_mem [BLFT_FRAME_DEPTH];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a transfer never completes
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // link state and config right after reset; the stores keep their contents
    function automatic void reset_link_model();
        lk_byte_timeout   = BYTE_TIMEOUT_RESET;
        lk_ack_code       = ACK_CODE_RESET;
        lk_nack_code      = NACK_CODE_RESET;
        lk_ack_flag       = 1'b0;
        lk_nack_flag      = 1'b0;
        lk_reply_flag     = 1'b0;
        lk_rx_mode        = RX_ACK;
        lk_rx_left        = '0;
        lk_rx_pos         = '0;
        lk_rx_timer       = '0;
        lk_response_timer = '0;
        lk_frame_fill     = '0;
        lk_tx_left        = '0;
        lk_tx_pos         = '0;
        lk_tx_active      = 1'b0;
        lk_tx_timer       = '0;
    endfunction

    // apply one event to the link state and return the status it reports
    function automatic t_out_item link_status_after(input t_in_item ev);
        t_out_item st;
        st = '0;
        case (ev.op)
            OP_RX_BYTE: begin
                lk_rx_timer = lk_byte_timeout;
                case (lk_rx_mode)
                    RX_ACK: begin
                        // ack code wins when both codes are equal
                        if (ev.data == lk_ack_code) begin
                            lk_ack_flag = 1'b1;
                        end else if (ev.data == lk_nack_code) begin
                            lk_nack_flag = 1'b1;
                        end
                        lk_rx_timer = '0;
                    end
                    RX_LEN: begin
                        lk_rx_left = ev.data;
                        lk_rx_mode = RX_DATA;
                        lk_rx_pos  = '0;
                    end
                    RX_DATA: begin
                        reply_mem[lk_rx_pos]     = ev.data;
                        reply_written[lk_rx_pos] = 1'b1;
                        reply_any                = 1'b1;
                        lk_rx_pos                = lk_rx_pos + 8'd1;
                        if (lk_rx_left == 8'd0) begin
                            lk_rx_timer   = '0;
                            lk_rx_mode    = RX_ACK;
                            lk_reply_flag = 1'b1;
                        end else begin
                            lk_rx_left = lk_rx_left - 8'd1;
                        end
                    end
                    default: begin
                        lk_rx_timer = '0;
                        lk_rx_mode  = RX_ACK;
                    end
                endcase
            end
            OP_TICK: begin
                if (lk_response_timer != 16'd0) begin
                    lk_response_timer = lk_response_timer - 16'd1;
                end
                // a timer already at zero is not running
                if (lk_tx_timer != 8'd0) begin
                    lk_tx_timer = lk_tx_timer - 8'd1;
                    if (lk_tx_timer == 8'd0) begin
                        lk_tx_active = 1'b0;
                        lk_tx_left   = '0;
                    end
                end
                if (lk_rx_timer != 8'd0) begin
                    lk_rx_timer = lk_rx_timer - 8'd1;
                    if (lk_rx_timer == 8'd0) begin
                        lk_rx_mode = RX_ACK;
                    end
                end
            end
            OP_ARM: begin
                lk_ack_flag       = 1'b0;
                lk_nack_flag      = 1'b0;
                lk_reply_flag     = 1'b0;
                lk_rx_mode        = ev.expect_reply ? RX_LEN : RX_ACK;
                lk_response_timer = ev.timeout_value;
            end
            OP_TX_PUSH: begin
                if (lk_tx_active) begin
                    st.rejected = 1'b1;
                end else begin
                    // bytes beyond the frame store are dropped
                    if (lk_frame_fill < BLFT_FRAME_DEPTH) begin
                        frame_mem[lk_frame_fill[7:0]] = ev.data;
                        lk_frame_fill                 = lk_frame_fill + 9'd1;
                    end
                    if (ev.last) begin
                        lk_tx_left    = lk_frame_fill;
                        lk_tx_pos     = '0;
                        lk_tx_active  = 1'b1;
                        lk_tx_timer   = lk_byte_timeout;
                        lk_frame_fill = '0;
                    end
                end
            end
            OP_TX_READY: begin
                if (lk_tx_active) begin
                    if (lk_tx_left != 9'd0) begin
                        lk_tx_left  = lk_tx_left - 9'd1;
                        lk_tx_timer = lk_byte_timeout;
                        st.tx_byte  = frame_mem[lk_tx_pos];
                        st.tx_valid = 1'b1;
                        lk_tx_pos   = lk_tx_pos + 8'd1;
                    end else begin
                        lk_tx_active = 1'b0;
                        lk_tx_timer  = '0;
                    end
                end
            end
            OP_READ_REPLY: begin
                st.read_byte = reply_mem[ev.index];
            end
            default: begin
            end
        endcase
        st.ack_seen      = lk_ack_flag;
        st.nack_seen     = lk_nack_flag;
        st.reply_done    = lk_reply_flag;
        st.response_left = lk_response_timer;
        st.tx_busy       = lk_tx_active;
        return st;
    endfunction

    // ---------------------------------------------------------------
    // status checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin : status_ready_drive
        int unsigned hold;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request != 0) begin
                hold          = stall_request;
                stall_request = 0;
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= i_rst_n && (no_idle || $urandom_range(99) >= 18);
        end
    end

    // every status transfer is matched against the oldest prediction
    always @(posedge i_clk) begin : status_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (expected_status.size() == 0) begin
                $error("status transfer with no event waiting for it");
                fail_count++;
            end else begin
                want = expected_status.pop_front();
                statuses_checked++;
                check_field("ack_seen", want.ack_seen, got.ack_seen);
                check_field("nack_seen", want.nack_seen, got.nack_seen);
                check_field("reply_done", want.reply_done, got.reply_done);
                check_field("response_left", want.response_left, got.response_left);
                check_field("tx_valid", want.tx_valid, got.tx_valid);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("tx_busy", want.tx_busy, got.tx_busy);
                check_field("rejected", want.rejected, got.rejected);
                check_field("read_byte", want.read_byte, got.read_byte);
            end
        end
    end

    // ---------------------------------------------------------------
    // event sending
    // ---------------------------------------------------------------

    // valid is only ever lowered by an idle cycle or a pause, so it never gets
    // two assignments in one step
    task automatic send_event(input t_in_item ev);
        while (!no_idle && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= ev;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_status.push_back(link_status_after(ev));
        events_sent++;
    endtask

    // fields the op does not use are random too
    function automatic t_in_item random_event(input logic [2:0] op);
        t_in_item ev;
        ev.op            = op;
        ev.data          = 8'($urandom);
        ev.last          = 1'($urandom);
        ev.expect_reply  = 1'($urandom);
        ev.timeout_value = 16'($urandom);
        ev.index         = 8'($urandom);
        return ev;
    endfunction

    task automatic send_rx(input logic [7:0] value);
        t_in_item ev;
        ev      = random_event(OP_RX_BYTE);
        ev.data = value;
        send_event(ev);
    endtask

    task automatic send_tick();
        send_event(random_event(OP_TICK));
    endtask

    task automatic send_arm(input logic want_reply, input logic [15:0] ticks);
        t_in_item ev;
        ev               = random_event(OP_ARM);
        ev.expect_reply  = want_reply;
        ev.timeout_value = ticks;
        send_event(ev);
    endtask

    task automatic send_push(input logic [7:0] value, input logic final_byte);
        t_in_item ev;
        ev      = random_event(OP_TX_PUSH);
        ev.data = value;
        ev.last = final_byte;
        send_event(ev);
    endtask

    task automatic send_tx_ready();
        send_event(random_event(OP_TX_READY));
    endtask

    // only reply entries that were written may be read back
    task automatic send_read(input logic [7:0] pos);
        t_in_item ev;
        ev       = random_event(OP_READ_REPLY);
        ev.index = pos;
        send_event(ev);
    endtask

    function automatic logic [7:0] pick_written_index();
        logic [7:0] pos;
        pos = 8'($urandom);
        while (!reply_written[pos]) pos = pos + 8'd1;
        return pos;
    endfunction

    function automatic logic [15:0] pick_timeout();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    endfunction

    // sender pause until every status has come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all three registers, one per cycle, only while the link is idle
    task automatic write_registers(input logic [7:0] timeout_ticks, input logic [7:0] ack,
                                   input logic [7:0] nack);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BYTE_TIMEOUT;
        i_cfg_wdata <= timeout_ticks;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ACK_CODE;
        i_cfg_wdata <= ack;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_NACK_CODE;
        i_cfg_wdata <= nack;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lk_byte_timeout = timeout_ticks;
        lk_ack_code     = ack;
        lk_nack_code    = nack;
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // random traffic: mostly well-formed exchanges with random content
    // ---------------------------------------------------------------

    task automatic run_link_mix(input int unsigned count);
        int unsigned stop;
        int unsigned kind;
        int unsigned len;
        int unsigned i;
        logic [2:0]  op;
        stop = events_sent + count;
        while (events_sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                // command answered by ack or nack
                send_arm(1'b0, pick_timeout());
                repeat ($urandom_range(0, 3)) send_tick();
                i = $urandom_range(9);
                send_rx(i < 4 ? lk_ack_code : (i < 7 ? lk_nack_code : 8'($urandom)));
            end else if (kind < 50) begin
                // length-prefixed reply, ticks in between may break it off
                send_arm(1'b1, pick_timeout());
                if ($urandom_range(99) < 10) send_tick();
                len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
                send_rx(8'(len));
                for (i = 0; i <= len; i++) begin
                    if ($urandom_range(99) < 8) send_tick();
                    send_rx(8'($urandom));
                end
                if (reply_any) begin
                    repeat ($urandom_range(0, 2)) send_read(pick_written_index());
                end
            end else if (kind < 75) begin
                // finish any frame still going, then send a short one
                while (lk_tx_active) send_tx_ready();
                len = $urandom_range(1, 6);
                for (i = 1; i <= len; i++) send_push(8'($urandom), i == len);
                if ($urandom_range(99) < 20) send_push(8'($urandom), 1'($urandom));
                for (i = 0; i <= len; i++) begin
                    if ($urandom_range(99) < 10) send_tick();
                    send_tx_ready();
                end
            end else begin
                // noise: any op, spare codes included
                repeat ($urandom_range(1, 4)) begin
                    op = 3'($urandom_range(7));
                    if (op == OP_READ_REPLY) begin
                        if (reply_any) send_read(pick_written_index());
                        else send_tick();
                    end else begin
                        send_event(random_event(op));
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // default config: timeout 20, ack 0x79, nack 0x1f
    task automatic test_directed_basics();
        send_tx_ready();                  // transmit-ready with no frame
        send_arm(1'b0, 16'hFFFF);
        send_rx(ACK_CODE_RESET);
        send_rx(NACK_CODE_RESET);
        send_rx(8'h00);                   // neither code
        send_tick();
        send_arm(1'b0, 16'h0000);         // response timer already expired
        send_tick();
        send_arm(1'b1, 16'h0003);
        send_rx(8'h01);                   // length: two bytes follow
        send_rx(8'hFF);
        send_rx(8'h00);
        send_read(8'h00);
        send_read(8'h01);
        send_push(8'h00, 1'b0);
        send_push(8'hFF, 1'b1);
        send_push(8'hA5, 1'b0);           // refused while the frame is out
        send_tx_ready();
        send_tx_ready();
        send_tx_ready();                  // nothing left, frame ends
        send_event(random_event(OP_SPARE_6));
        send_event(random_event(OP_SPARE_7));
        wait_idle();
    endtask

    task automatic test_timer_expiry();
        write_registers(8'd2, 8'h00, 8'hFF);
        send_arm(1'b1, 16'd5);
        send_rx(8'd3);
        send_rx(8'h11);
        send_tick();
        send_tick();                      // receive gives up, back to ack mode
        send_rx(8'h00);                   // now taken as an ack
        send_rx(8'hFF);
        send_push(8'h3C, 1'b0);
        send_push(8'hC3, 1'b1);
        send_tx_ready();
        send_tick();
        send_tick();                      // transmit aborts mid-frame
        send_tx_ready();
        send_push(8'h5A, 1'b1);           // accepted again after the abort
        send_tx_ready();
        send_tx_ready();
        // zero timeout disables both per-byte timers; equal codes, ack wins
        write_registers(8'd0, 8'hFF, 8'hFF);
        send_arm(1'b1, 16'd2);
        send_rx(8'd0);
        repeat (3) send_tick();
        send_rx(8'h77);
        send_read(8'h00);
        send_arm(1'b0, 16'd1);
        send_rx(8'hFF);
        send_push(8'h81, 1'b1);
        repeat (3) send_tick();
        send_tx_ready();
        send_tx_ready();
        wait_idle();
    endtask

    // longest reply fills the whole store, then random read-back
    task automatic test_long_reply();
        int unsigned i;
        write_registers(8'd255, ACK_CODE_RESET, NACK_CODE_RESET);
        send_arm(1'b1, 16'hFFFF);
        send_rx(8'd255);
        for (i = 0; i < 256; i++) begin
            if ($urandom_range(99) < 5) send_tick();
            send_rx(8'($urandom));
        end
        send_read(8'h00);
        send_read(8'hFF);
        repeat (20) send_read(8'($urandom));
        wait_idle();
    endtask

    // more bytes than the frame store holds; the extra ones must not wrap over
    // the first stored bytes, then the transmit timer aborts the frame
    task automatic test_frame_overflow();
        int unsigned i;
        while (lk_tx_active) send_tx_ready();
        write_registers(8'd3, ACK_CODE_RESET, NACK_CODE_RESET);
        for (i = 0; i < 260; i++) send_push(8'($urandom), i == 259);
        for (i = 0; i < 8; i++) send_tx_ready();
        repeat (4) send_tick();
        send_tx_ready();                  // frame already aborted
        wait_idle();
    endtask

    // receiver holds off while events keep coming, so the input stalls
    task automatic test_backpressure();
        no_idle       = 1'b1;
        stall_request = 60;
        run_link_mix(30);
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_mix();
        int unsigned phase;
        int unsigned pick;
        logic [7:0]  timeout_ticks;
        logic [7:0]  ack;
        for (phase = 0; phase < 5; phase++) begin
            pick = $urandom_range(5);
            timeout_ticks = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd2 :
                            (pick == 3) ? 8'd255 : 8'($urandom);
            ack = 8'($urandom);
            write_registers(timeout_ticks, ack,
                            ($urandom_range(4) == 0) ? ack : 8'($urandom));
            // one longer phase runs with no idling on either side
            no_idle = (phase == 2);
            run_link_mix((phase == 2) ? 60 : 20);
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin : main_sequence
        int unsigned waited;
        fail_count       = 0;
        events_sent      = 0;
        statuses_checked = 0;
        settings_used    = 0;
        no_idle          = 1'b0;
        stall_request    = 0;
        reply_any        = 1'b0;
        reset_link_model();

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_BYTE_TIMEOUT;
        i_cfg_wdata   <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_timer_expiry();
        test_long_reply();
        test_frame_overflow();
        test_backpressure();
        test_random_mix();

        // final drain, bounded
        in_ch.valid <= 1'b0;
        waited = 0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_status.size() != 0) begin
            $error("%0d status transfers never arrived", expected_status.size());
            fail_count++;
        end

        $display("link run: %0d events under %0d register settings, %0d status transfers checked",
                 events_sent, settings_used, statuses_checked);
        $display("covered ack/nack, replies up to full store, frame overflow, timer expiry, stalls");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
